// File: src/wildcard_byte_pattern_scanner_top_macros.svh
// Assertion macros shared by the wildcard byte pattern scanner modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WBPS_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/wbps_pkg.sv
// Package of the wildcard byte pattern scanner: sizes, register codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;
  localparam int PAT_BYTES         = 16;
  localparam int EFF_MAX           = (PAT_BYTES < MAX_PATTERN_BYTES) ?
                                     PAT_BYTES : MAX_PATTERN_BYTES;
  localparam int IDX_W             = (PAT_BYTES > 1) ? $clog2(PAT_BYTES) : 1;
  localparam int LEN_W             = $clog2(EFF_MAX + 1);
  localparam int RAW_LEN_W         = 5;
  localparam int ADDR_W            = 64;
  localparam int COUNT_W           = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [COUNT_W-1:0]     COUNT_MAX  = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOWER = 3'd0,
    REG_PATTERN_UPPER = 3'd1,
    REG_CARE_MASK     = 3'd2,
    REG_PATTERN_LEN   = 3'd3,
    REG_RESULT_LIMIT  = 3'd4,
    REG_REGION_BASE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
    logic [COUNT_W-1:0]        limit;
    logic [ADDR_W-1:0]         base;
  } cfg_t;

  typedef struct packed {
    logic                   cand;
    logic                   last;
    logic [OFFSET_BITS-1:0] offset;
  } scan_item_t;

endpackage

// File: src/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner: configuration registers,
// front part, queue and back part. Depends on wbps_pkg and the three submodules.
//
//   channel  dir  handshake            payload
//   cfg      in   cfg_valid/ready      cfg_index, cfg_data
//   s_axis   in   s_axis_tvalid/tready tdata = data_byte, tlast = last_byte
//   m_axis   out  m_axis_tvalid/tready tdata, tuser = match_valid, tlast = end_of_scan
//
// One input word is taken every cycle while the four-entry queue has room.
// A result word passes through the queue and then the back part's output register.
// The back part retires one queued word per cycle while its output register is free.
// Reset clears the window, counters, queue and registers; result_limit resets to 1.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // data_byte
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wbps_pkg::ADDR_W+wbps_pkg::COUNT_W-1:0] m_axis_tdata, // match_address, matches_found
  output logic                              m_axis_tuser,   // match_valid
  output logic                              m_axis_tlast
);
  import wbps_pkg::*;

  logic [ADDR_W-1:0]    pat_lower;
  logic [ADDR_W-1:0]    pat_upper;
  logic [PAT_BYTES-1:0] care_mask;
  logic [RAW_LEN_W-1:0] pattern_length;
  logic [COUNT_W-1:0]   result_limit;
  logic [ADDR_W-1:0]    region_base;
  cfg_t                 cfg;

  logic                 push;
  scan_item_t           push_item;
  logic                 queue_full;
  logic                 pop;
  scan_item_t           pop_item;
  logic                 queue_valid;
  logic [ADDR_W-1:0]    out_address;
  logic [COUNT_W-1:0]   out_found;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lower      <= '0;
      pat_upper      <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
      result_limit   <= COUNT_W'(1);
      region_base    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOWER: pat_lower      <= cfg_data;
        REG_PATTERN_UPPER: pat_upper      <= cfg_data;
        REG_CARE_MASK:     care_mask      <= cfg_data[PAT_BYTES-1:0];
        REG_PATTERN_LEN:   pattern_length <= cfg_data[RAW_LEN_W-1:0];
        REG_RESULT_LIMIT:  result_limit   <= cfg_data[COUNT_W-1:0];
        REG_REGION_BASE:   region_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern = {pat_upper, pat_lower};
    cfg.care    = care_mask;
    cfg.len     = (pattern_length > RAW_LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX) :
                  LEN_W'(pattern_length);
    cfg.limit   = result_limit;
    cfg.base    = region_base;
  end

  wbps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  wbps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (queue_valid)
  );

  wbps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (queue_valid),
    .item        (pop_item),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_address (out_address),
    .out_found   (out_found),
    .out_match   (m_axis_tuser),
    .out_end     (m_axis_tlast)
  );

  assign m_axis_tdata = {out_found, out_address};

endmodule

// File: src/wbps_front.sv
// Front part: takes input bytes, keeps the byte window and byte count, and
// classifies each byte as a match candidate. Depends on wbps_pkg.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scanner_top_macros.svh"

module wbps_front (
  input  logic                clk,
  input  logic                rst,
  input  wbps_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                push,
  output wbps_pkg::scan_item_t push_item,
  input  logic                queue_full
);
  import wbps_pkg::*;

  logic [7:0]             window [MAX_PATTERN_BYTES];
  logic [7:0]             shifted [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic                   addressable;
  logic                   window_hit;
  logic                   fits;
  logic                   accept;
  logic                   win_any;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    shifted[0] = in_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      shifted[i] = window[i-1];
    end
  end

  assign addressable     = (bytes_seen != OFFSET_MAX);
  assign bytes_seen_next = addressable ? bytes_seen + 1'b1 : bytes_seen;
  assign fits            = (bytes_seen_next >= OFFSET_BITS'(cfg.len));

  // Window slot j holds pattern byte len-1-j, the newest byte ends the pattern.
  always_comb begin
    logic [LEN_W-1:0] k;
    window_hit = 1'b1;
    for (int j = 0; j < EFF_MAX; j++) begin
      k = cfg.len - LEN_W'(1) - LEN_W'(j);
      if (LEN_W'(j) < cfg.len) begin
        if (cfg.care[k[IDX_W-1:0]] && (shifted[j] != cfg.pattern[k[IDX_W-1:0]])) begin
          window_hit = 1'b0;
        end
      end
    end
  end

  always_comb begin
    push_item.last = in_last;
    if (cfg.len == '0) begin
      push_item.cand   = addressable && (bytes_seen == '0);
      push_item.offset = '0;
    end else begin
      push_item.cand   = addressable && fits && window_hit;
      push_item.offset = bytes_seen_next - OFFSET_BITS'(cfg.len);
    end
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) window[i] <= '0;
    end else if (accept) begin
      bytes_seen <= in_last ? '0 : bytes_seen_next;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        window[i] <= in_last ? 8'd0 : shifted[i];
      end
    end
  end

  always_comb begin
    win_any = 1'b0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) win_any = win_any | (|window[i]);
  end

  `WBPS_ASSERT_HOLDS(a_empty_window, bytes_seen == '0, !win_any, "window not clear at scan start")

endmodule

// File: src/wbps_fifo.sv
// Short queue of classified words between the front and back parts.
// Depends on wbps_pkg for the entry type and depth.
`timescale 1ns / 1ps

module wbps_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wbps_pkg::scan_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output wbps_pkg::scan_item_t pop_item,
  output logic                 not_empty
);
  import wbps_pkg::*;

  scan_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/wbps_back.sv
// Back part: applies the result limit, forms match addresses and holds the
// result word in an output register. Depends on wbps_pkg.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scanner_top_macros.svh"

module wbps_back (
  input  logic                 clk,
  input  logic                 rst,
  input  wbps_pkg::cfg_t       cfg,
  input  logic                 item_valid,
  input  wbps_pkg::scan_item_t item,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [wbps_pkg::ADDR_W-1:0]  out_address,
  output logic [wbps_pkg::COUNT_W-1:0] out_found,
  output logic                 out_match,
  output logic                 out_end
);
  import wbps_pkg::*;

  logic [COUNT_W-1:0] match_total;
  logic [COUNT_W-1:0] match_total_next;
  logic               scan_stopped;
  logic               hit;
  logic               emit;

  assign pop  = item_valid && (!out_valid || out_ready);
  assign hit  = item.cand && !scan_stopped;
  assign emit = hit || item.last;
  assign match_total_next = (hit && (match_total != COUNT_MAX)) ?
                            match_total + 1'b1 : match_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_total  <= '0;
      scan_stopped <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        if (item.last) begin
          match_total  <= '0;
          scan_stopped <= 1'b0;
        end else begin
          match_total <= match_total_next;
          if (hit && (match_total_next >= cfg.limit)) scan_stopped <= 1'b1;
        end
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_address <= hit ? cfg.base + ADDR_W'(item.offset) : '0;
      out_match   <= hit;
      out_end     <= item.last;
      out_found   <= match_total_next;
    end
  end

  `WBPS_ASSERT_HOLDS(a_stop_count, scan_stopped, match_total != '0, "stopped with no matches")
  `WBPS_ASSERT_HOLDS(a_match_found, out_valid && out_match, out_found != '0, "match with zero count")
  `WBPS_ASSERT_NEXT(a_scan_clear, pop && item.last, (match_total == '0) && !scan_stopped, "scan state kept after last word")

endmodule

// File: tb/sv/wildcard_byte_pattern_scanner_top_tb.sv
// Testbench of wildcard_byte_pattern_scanner_top: a directed table, then random scans under
// several idle and stall mixes; each result word is checked against a fixed expected
// value or a scan predictor. Depends on wbps_pkg and the scanner RTL.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_top_tb;
  import wbps_pkg::*;

  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_BYTES    = 100;
  localparam int PRESSURE_PHASE = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic               valid;
    logic               eos;
    logic [COUNT_W-1:0] count;
  } match_report_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [7:0]            data;
    logic                  last;
    logic                  fixed;
    match_report_t         want;
  } directed_row_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata;   // data_byte
  logic                        s_axis_tlast;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [ADDR_W+COUNT_W-1:0]   m_axis_tdata;   // match_address, matches_found
  logic                        m_axis_tuser;   // match_valid
  logic                        m_axis_tlast;

  logic [63:0]            pat_lo;
  logic [63:0]            pat_hi;
  logic [63:0]            base_addr;
  logic [15:0]            care_bits;
  logic [15:0]            hit_limit;
  logic [4:0]             raw_len;
  logic [7:0]             window [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] offset_count;
  logic [COUNT_W-1:0]     hit_count;
  logic                   scan_done;

  match_report_t reports_due[$];
  directed_row_t directed_rows[$];
  int            err_count = 0;
  int            idle_cycles = 0;
  int            tx_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            hold_left = 0;
  bit            hold_request = 1'b0;
  int unsigned   bytes_sent = 0;

  wildcard_byte_pattern_scanner_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned used_length();
    return (raw_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : raw_len;
  endfunction

  function automatic logic [7:0] pattern_byte(input int unsigned k);
    logic [127:0] both;
    both = {pat_hi, pat_lo};
    return both[8*k +: 8];
  endfunction

  function automatic void clear_scan();
    foreach (window[i]) window[i] = 8'h00;
    offset_count = '0;
    hit_count = '0;
    scan_done = 1'b0;
  endfunction

  function automatic logic match_step(input logic [7:0] b, input logic last,
                                      output match_report_t rep);
    int unsigned len;
    int          i;
    logic        first;
    logic        hit;
    logic        agree;
    logic [ADDR_W-1:0] start_addr;
    len = used_length();
    first = (offset_count == '0);
    hit = 1'b0;
    start_addr = '0;
    for (i = MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (offset_count != OFFSET_MAX) begin
      offset_count++;
      if (!scan_done) begin
        if (len == 0) begin
          hit = first;
          start_addr = first ? base_addr : '0;
        end else if (offset_count >= len) begin
          agree = 1'b1;
          for (i = 0; i < len; i++) begin
            if (care_bits[i] && window[len-1-i] != pattern_byte(i)) agree = 1'b0;
          end
          if (agree) begin
            hit = 1'b1;
            start_addr = base_addr + ADDR_W'(offset_count) - ADDR_W'(len);
          end
        end
      end
    end
    if (hit) begin
      if (hit_count != COUNT_MAX) hit_count++;
      if (hit_count >= hit_limit) scan_done = 1'b1;
    end
    rep = '{addr: start_addr, valid: hit, eos: last, count: hit_count};
    if (last) clear_scan();
    return hit || last;
  endfunction

  function automatic directed_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [63:0] v);
    directed_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.value = v;
    return r;
  endfunction

  function automatic directed_row_t byte_row(input logic [7:0] d, input logic last);
    directed_row_t r;
    r = '0;
    r.data = d;
    r.last = last;
    return r;
  endfunction

  function automatic directed_row_t checked_row(input logic [7:0] d, input logic last,
                                                input logic [63:0] addr, input logic valid,
                                                input logic eos, input logic [15:0] count);
    directed_row_t r;
    r = byte_row(d, last);
    r.fixed = 1'b1;
    r.want = '{addr: addr, valid: valid, eos: eos, count: count};
    return r;
  endfunction

  task automatic send_scan_byte(input logic [7:0] b, input logic last,
                                input logic fixed, input match_report_t want);
    match_report_t rep;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    if (match_step(b, last, rep)) reports_due.push_back(fixed ? want : rep);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_PATTERN_LOWER: pat_lo = v;
      REG_PATTERN_UPPER: pat_hi = v;
      REG_CARE_MASK:     care_bits = v[15:0];
      REG_PATTERN_LEN:   raw_len = v[4:0];
      REG_RESULT_LIMIT:  hit_limit = v[15:0];
      REG_REGION_BASE:   base_addr = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_scan(input logic finish);
    int unsigned n;
    int unsigned pos;
    int unsigned len;
    int unsigned k;
    int unsigned bad;
    logic [7:0]  b;
    n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
    len = used_length();
    pos = 0;
    while (pos < n) begin
      if (len > 0 && pos + len <= n && $urandom_range(2) == 0) begin
        bad = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : len;
        for (k = 0; k < len; k++) begin
          b = care_bits[k] ? pattern_byte(k) : 8'($urandom());
          if (k == bad) b = ~b;
          send_scan_byte(b, finish && pos == n - 1, 1'b0, '0);
          pos++;
        end
      end else begin
        b = ($urandom_range(1) == 0) ? pattern_byte($urandom_range(15)) : 8'($urandom());
        send_scan_byte(b, finish && pos == n - 1, 1'b0, '0);
        pos++;
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    match_report_t got;
    match_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.addr = m_axis_tdata[ADDR_W-1:0];
      got.count = m_axis_tdata[ADDR_W +: COUNT_W];
      got.valid = m_axis_tuser;
      got.eos = m_axis_tlast;
      if (reports_due.size() == 0) begin
        err_count++;
        $error("result word with nothing expected: match_address %h", got.addr);
      end else begin
        want = reports_due.pop_front();
        if (got.addr !== want.addr) begin
          err_count++;
          $error("match_address: expected %h, got %h", want.addr, got.addr);
        end
        if (got.valid !== want.valid) begin
          err_count++;
          $error("match_valid: expected %b, got %b", want.valid, got.valid);
        end
        if (got.eos !== want.eos) begin
          err_count++;
          $error("end_of_scan: expected %b, got %b", want.eos, got.eos);
        end
        if (got.count !== want.count) begin
          err_count++;
          $error("matches_found: expected %0d, got %0d", want.count, got.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    directed_row_t row;
    logic          prev_reg;
    int            phase;
    int            r;
    int unsigned   phase_start;
    logic [63:0]   junk;
    logic [4:0]    len_v;
    logic [15:0]   care_v;
    logic [15:0]   limit_v;
    logic [63:0]   base_v;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;

    pat_lo = '0;
    pat_hi = '0;
    base_addr = '0;
    care_bits = '0;
    raw_len = '0;
    hit_limit = 16'd1;
    clear_scan();

    directed_rows = '{
      checked_row(8'h00, 1'b0, 64'h0, 1'b1, 1'b0, 16'd1),
      checked_row(8'hFF, 1'b1, 64'h0, 1'b0, 1'b1, 16'd1),
      checked_row(8'h5A, 1'b1, 64'h0, 1'b1, 1'b1, 16'd1),
      reg_row(REG_PATTERN_LOWER, 64'h0000_0000_00CC_BBAA),
      reg_row(REG_PATTERN_UPPER, 64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(REG_CARE_MASK, 64'h0000_0000_0000_FFFF),
      reg_row(REG_PATTERN_LEN, 64'd3),
      reg_row(REG_RESULT_LIMIT, 64'd2),
      reg_row(REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFE),
      byte_row(8'hAA, 1'b0),
      byte_row(8'hBB, 1'b0),
      byte_row(8'hCC, 1'b0),
      byte_row(8'hAA, 1'b0),
      byte_row(8'hBB, 1'b0),
      byte_row(8'hCC, 1'b0),
      byte_row(8'hAA, 1'b1),
      reg_row(REG_PATTERN_LEN, 64'd31),
      reg_row(REG_CARE_MASK, 64'h0),
      reg_row(REG_RESULT_LIMIT, 64'h0),
      byte_row(8'h00, 1'b0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'h5A, 1'b1),
      reg_row(REG_PATTERN_LEN, 64'd1),
      reg_row(REG_CARE_MASK, 64'h1),
      reg_row(REG_PATTERN_LOWER, 64'hFF),
      reg_row(REG_RESULT_LIMIT, 64'hFFFF),
      reg_row(REG_REGION_BASE, 64'h0123_4567_89AB_CDEF),
      reg_row(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF),
      reg_row(REG_SPARE_B, 64'h0),
      byte_row(8'hFF, 1'b0),
      byte_row(8'h00, 1'b0),
      byte_row(8'hFF, 1'b1)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    prev_reg = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) begin
        if (!prev_reg) settle();
        write_reg(row.idx, row.value);
      end else begin
        if (prev_reg) cfg_valid <= 1'b0;
        send_scan_byte(row.data, row.last, row.fixed, row.want);
      end
      prev_reg = row.is_reg;
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 67;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 67;
        end
        default: begin
          tx_idle_pct = 38;
          rx_stall_pct = 38;
        end
      endcase

      r = $urandom_range(9);
      len_v = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(31, 17)) :
              (r == 2) ? 5'd16 : (r < 6) ? 5'($urandom_range(4, 1)) :
              5'($urandom_range(15, 5));
      r = $urandom_range(5);
      care_v = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
      r = $urandom_range(5);
      limit_v = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'hFFFF :
                (r == 5) ? 16'($urandom()) : 16'($urandom_range(6, 2));
      r = $urandom_range(3);
      base_v = (r == 0) ? 64'h0 : (r == 1) ? 64'hFFFF_FFFF_FFFF_FFFF :
               {$urandom(), $urandom()};
      if (phase == PRESSURE_PHASE) begin
        len_v = 5'd1;
        care_v = 16'h0000;
        limit_v = 16'hFFFF;
      end
      junk = ($urandom_range(1) == 1) ? {$urandom(), $urandom()} : 64'h0;

      write_reg(REG_PATTERN_LOWER, {$urandom(), $urandom()});
      write_reg(REG_PATTERN_UPPER, {$urandom(), $urandom()});
      write_reg(REG_CARE_MASK, {junk[63:16], care_v});
      write_reg(REG_PATTERN_LEN, {junk[63:5], len_v});
      write_reg(REG_RESULT_LIMIT, {junk[63:16], limit_v});
      write_reg(REG_REGION_BASE, base_v);
      if ($urandom_range(2) == 0) begin
        write_reg(($urandom_range(1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                  {$urandom(), $urandom()});
      end
      cfg_valid <= 1'b0;

      if (phase == PRESSURE_PHASE) hold_request = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_scan(1'b1);
      if ($urandom_range(3) == 0) send_random_scan(1'b0);
    end

    settle();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/wbps_pkg.sv
src/wbps_front.sv
src/wbps_fifo.sv
src/wbps_back.sv
src/wildcard_byte_pattern_scanner_top.sv
tb/sv/wildcard_byte_pattern_scanner_top_tb.sv
